FILE: rtl/fys_pkg.sv
// shared types and constants for the fisher-yates shuffle block
package fys_pkg;

  localparam int POS_W   = 16;
  localparam int VAL_W   = 32;
  localparam int RND_W   = 31;
  localparam int CNT_W   = 17;
  localparam int REQ_W   = 2;
  localparam int REM_W   = 17;

  // divider retires two quotient bits per cycle over a 32-bit dividend
  localparam int DIV_STEPS = 16;
  localparam int DIV_CW    = 4;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic load;      // latch an accepted item, clear result
    logic wr_entry;  // store word at position, re-arm cursor
    logic set_done;  // step found nothing to swap
    logic rd_pos;    // read entry at position
    logic cap_read;  // capture read data into result
    logic div_start; // start remainder computation
    logic div_step;  // one divider iteration
    logic rd_i;      // read entry at cursor, record partner
    logic rd_j;      // read entry at partner, hold cursor word
    logic wr_i;      // write partner word at cursor
    logic wr_j;      // write cursor word at partner, step cursor down
    logic out_load;  // move result into output register
  } fys_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             pos_ok;
    logic             step_idle;
    logic             div_last;
  } fys_stat_t;

endpackage

FILE: rtl/fys_ctrl.sv
// sequencer for write, read and shuffle-step transfers
module fys_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  fys_pkg::fys_stat_t stat,
  output fys_pkg::fys_cmd_t  cmd
);
  import fys_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RDWAIT = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_RD_I   = 4'd4;
  localparam logic [3:0] S_RD_J   = 4'd5;
  localparam logic [3:0] S_WR_I   = 4'd6;
  localparam logic [3:0] S_WR_J   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.req)
          REQ_WRITE: begin
            cmd.wr_entry = 1'b1;
            state_nxt    = S_FINISH;
          end
          REQ_STEP: begin
            if (stat.step_idle) begin
              cmd.set_done = 1'b1;
              state_nxt    = S_FINISH;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          REQ_READ: begin
            if (stat.pos_ok) begin
              cmd.rd_pos = 1'b1;
              state_nxt  = S_RDWAIT;
            end else begin
              state_nxt = S_FINISH;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.cap_read = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_RD_I;
        end
      end
      S_RD_I: begin
        cmd.rd_i  = 1'b1;
        state_nxt = S_RD_J;
      end
      S_RD_J: begin
        cmd.rd_j  = 1'b1;
        state_nxt = S_WR_I;
      end
      S_WR_I: begin
        cmd.wr_i  = 1'b1;
        state_nxt = S_WR_J;
      end
      S_WR_J: begin
        cmd.wr_j  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // wait until the output register is empty or being drained
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/fys_dp.sv
// entry memory, cursor, remainder unit and result registers
module fys_dp #(
  parameter int DEPTH = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fys_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic [fys_pkg::REQ_W-1:0]     in_req,
  input  logic [fys_pkg::POS_W-1:0]     in_pos,
  input  logic [fys_pkg::VAL_W-1:0]     in_val,
  input  logic [fys_pkg::RND_W-1:0]     in_rnd,
  input  fys_pkg::fys_cmd_t             cmd,
  output fys_pkg::fys_stat_t            stat,
  output logic [fys_pkg::OUT_DATA_W-1:0] out_data
);
  import fys_pkg::*;

  // only the first 64k entries are reachable through a 16-bit position
  localparam int MEM_DEPTH = (DEPTH > 65536) ? 65536 : DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic [CNT_W-1:0] MEM_DEPTH_C = CNT_W'(MEM_DEPTH);
  localparam logic POS_ALL = (DEPTH >= 65536);

  logic [VAL_W-1:0] mem [0:MEM_DEPTH-1];
  logic [VAL_W-1:0] mem_q_r;

  logic [CNT_W-1:0] count_r;
  logic [POS_W-1:0] cursor_r, cursor_nxt;
  logic [REQ_W-1:0] req_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [RND_W-1:0] rnd_r;

  logic [31:0]       quo_r;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  dvs_r;
  logic [DIV_CW-1:0] dcnt_r;
  logic [REM_W-1:0]  rem_a, rem_b;
  logic [REM_W:0]    trial_a, trial_b;

  logic [VAL_W-1:0] ti_r;
  logic [VAL_W-1:0] res_read_r;
  logic [POS_W-1:0] res_partner_r;
  logic             res_done_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [CNT_W-1:0] eff_count;
  logic             pos_ok;
  logic [AW-1:0]    addr_pos, addr_i, addr_j;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             rd_en, wr_en;

  assign eff_count = (count_r > MEM_DEPTH_C) ? MEM_DEPTH_C : count_r;
  assign pos_ok    = POS_ALL || ({1'b0, pos_r} < MEM_DEPTH_C);

  assign addr_pos = pos_r[AW-1:0];
  assign addr_i   = cursor_r[AW-1:0];
  assign addr_j   = rem_r[AW-1:0];

  assign stat.req       = req_r;
  assign stat.pos_ok    = pos_ok;
  assign stat.step_idle = (cursor_r == '0) || (count_r <= CNT_W'(1));
  assign stat.div_last  = (dcnt_r == DIV_CW'(DIV_STEPS - 1));

  // two restoring remainder steps per cycle
  always_comb begin
    trial_a = {rem_r, quo_r[31]};
    rem_a   = (trial_a >= {1'b0, dvs_r}) ? REM_W'(trial_a - {1'b0, dvs_r})
                                         : trial_a[REM_W-1:0];
    trial_b = {rem_a, quo_r[30]};
    rem_b   = (trial_b >= {1'b0, dvs_r}) ? REM_W'(trial_b - {1'b0, dvs_r})
                                         : trial_b[REM_W-1:0];
  end

  always_comb begin
    rd_en   = cmd.rd_pos || cmd.rd_i || cmd.rd_j;
    rd_addr = cmd.rd_pos ? addr_pos : (cmd.rd_i ? addr_i : addr_j);
    wr_en   = (cmd.wr_entry && pos_ok) || cmd.wr_i || cmd.wr_j;
    wr_addr = cmd.wr_entry ? addr_pos : (cmd.wr_i ? addr_i : addr_j);
    wr_data = cmd.wr_entry ? val_r : (cmd.wr_i ? mem_q_r : ti_r);
  end

  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.wr_entry) begin
      cursor_nxt = (eff_count == '0) ? '0 : POS_W'(eff_count - CNT_W'(1));
    end else if (cmd.wr_j) begin
      cursor_nxt = cursor_r - POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r         <= in_req;
      pos_r         <= in_pos;
      val_r         <= in_val;
      rnd_r         <= in_rnd;
      res_read_r    <= '0;
      res_partner_r <= '0;
      res_done_r    <= 1'b0;
    end
    if (cmd.set_done) begin
      res_done_r <= 1'b1;
    end
    if (cmd.cap_read) begin
      res_read_r <= mem_q_r;
    end
    if (cmd.div_start) begin
      quo_r  <= {1'b0, rnd_r};
      rem_r  <= '0;
      dvs_r  <= {1'b0, cursor_r} + REM_W'(1);
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[29:0], 2'b00};
      rem_r  <= rem_b;
      dcnt_r <= dcnt_r + DIV_CW'(1);
    end
    if (cmd.rd_i) begin
      res_partner_r <= rem_r[POS_W-1:0];
    end
    if (cmd.rd_j) begin
      ti_r <= mem_q_r;
    end
    if (cmd.out_load) begin
      out_data_r <= {7'd0, res_done_r, res_partner_r, res_read_r};
    end
  end

  assign out_data = out_data_r;

endmodule

FILE: rtl/fisher_yates_shuffle.sv
// top level of the fisher-yates shuffle block
// a write, an out-of-range read or a step with nothing to swap goes from decode to
// the finish state; an in-range read also waits on the memory read; a swapping step
// runs the remainder unit, which retires two bits a cycle, then two reads and two writes on the
// single-port entry memory; one item is in flight at a time, plus one result
// waiting in the output register. synchronous active-low reset clears cursor,
// entry count and handshake state; entry memory is not cleared
module fisher_yates_shuffle #(
  parameter int DEPTH = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fys_pkg::CNT_W-1:0]      cfg_wdata,   // entry_count
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fys_pkg::IN_DATA_W-1:0]  in_tdata,    // position, entry_value, random_word
  input  logic [fys_pkg::REQ_W-1:0]      in_tuser,    // req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fys_pkg::OUT_DATA_W-1:0] out_tdata    // read_value, swap_partner, shuffle_done
);
  import fys_pkg::*;

  fys_cmd_t  cmd;
  fys_stat_t stat;

  fys_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  fys_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_tuser),
    .in_pos    (in_tdata[15:0]),
    .in_val    (in_tdata[47:16]),
    .in_rnd    (in_tdata[78:48]),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_tdata)
  );

endmodule

FILE: bench/testbench.sv
// self-checking stream testbench for the fisher-yates shuffle block
`timescale 1ns / 100ps

module testbench;
  import fys_pkg::*;

  localparam int          ENTRY_DEPTH    = 65536;
  localparam int          HALF_PERIOD    = 6;
  localparam int          SETTLE_CYCLES  = 30;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          PRINT_LIMIT    = 40;
  localparam logic [1:0]  REQ_NONE       = 2'd3;

  typedef struct packed {
    logic             shuffle_done;
    logic [POS_W-1:0] swap_partner;
    logic [VAL_W-1:0] read_value;
  } shuffle_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CNT_W-1:0]      cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // position, entry_value, random_word
  logic [REQ_W-1:0]      in_tuser;   // req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // read_value, swap_partner, shuffle_done

  // shadow of the block state
  bit [VAL_W-1:0]  entry_mirror [ENTRY_DEPTH];
  bit              was_written  [ENTRY_DEPTH];
  int unsigned     written_list [$];
  bit [POS_W-1:0]  cursor_q;
  bit [CNT_W-1:0]  count_q;

  shuffle_result_t pending_results [$];

  int error_count    = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_reqs      = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  fisher_yates_shuffle #(
    .DEPTH(ENTRY_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  function automatic shuffle_result_t apply_request(logic [1:0] kind, logic [POS_W-1:0] pos,
                                                    logic [VAL_W-1:0] val,
                                                    logic [RND_W-1:0] rnd);
    shuffle_result_t res;
    int unsigned     n;
    bit [POS_W-1:0]  j;
    bit [VAL_W-1:0]  tmp;
    res = '0;
    case (kind)
      REQ_WRITE: begin
        n = (count_q > ENTRY_DEPTH) ? ENTRY_DEPTH : count_q;
        if (pos < ENTRY_DEPTH) begin
          entry_mirror[pos] = val;
          if (!was_written[pos]) begin
            was_written[pos] = 1'b1;
            written_list.push_back(pos);
          end
        end
        cursor_q = (n == 0) ? '0 : POS_W'(n - 1);
      end
      REQ_STEP: begin
        if (cursor_q == 0 || count_q <= 1) begin
          res.shuffle_done = 1'b1;
        end else begin
          j = POS_W'(rnd % (cursor_q + 1));
          tmp = entry_mirror[cursor_q];
          entry_mirror[cursor_q] = entry_mirror[j];
          entry_mirror[j] = tmp;
          res.swap_partner = j;
          cursor_q = cursor_q - 1'b1;
        end
      end
      REQ_READ: begin
        if (pos < ENTRY_DEPTH) res.read_value = entry_mirror[pos];
      end
      default: ;
    endcase
    return res;
  endfunction

  // random word that lands on the given partner for the current cursor
  function automatic logic [RND_W-1:0] word_for_partner(int unsigned j);
    longint unsigned span;
    longint unsigned kmax;
    span = longint'(cursor_q) + 1;
    kmax = (64'h7FFF_FFFF - j) / span;
    return RND_W'(j + span * $urandom_range(int'(kmax), 0));
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < PRINT_LIMIT)
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_item(logic [1:0] kind, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                           logic [RND_W-1:0] rnd);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, rnd, val, pos};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_request(kind, pos, val, rnd));
    items_sent++;
  endtask

  // drop valid and let every outstanding result drain
  task automatic quiesce();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entry_count(logic [CNT_W-1:0] value);
    quiesce();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    count_q = value;
    @(posedge clk);
  endtask

  task automatic write_entry(int unsigned pos, logic [VAL_W-1:0] val);
    send_item(REQ_WRITE, POS_W'(pos), val, RND_W'($urandom));
  endtask

  task automatic read_entry(int unsigned pos);
    send_item(REQ_READ, POS_W'(pos), $urandom, RND_W'($urandom));
  endtask

  task automatic step_to(int unsigned j);
    send_item(REQ_STEP, POS_W'($urandom), $urandom, word_for_partner(j));
  endtask

  task automatic read_random_entry();
    if (written_list.size() == 0) return;
    read_entry(written_list[$urandom_range(written_list.size() - 1)]);
  endtask

  // random step that never swaps through an entry not yet written
  task automatic step_random();
    logic [RND_W-1:0] word;
    bit [POS_W-1:0]   j;
    word = RND_W'($urandom);
    if (cursor_q != 0 && count_q > 1) begin
      if (!was_written[cursor_q]) return;
      j = POS_W'(word % (cursor_q + 1));
      if (!was_written[j]) word = word_for_partner(cursor_q);
    end
    send_item(REQ_STEP, POS_W'($urandom), $urandom, word);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_reqs != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    shuffle_result_t want;
    shuffle_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(shuffle_result_t)-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.read_value !== want.read_value)
          report_mismatch("read_value", got.read_value, want.read_value);
        if (got.swap_partner !== want.swap_partner)
          report_mismatch("swap_partner", got.swap_partner, want.swap_partner);
        if (got.shuffle_done !== want.shuffle_done)
          report_mismatch("shuffle_done", got.shuffle_done, want.shuffle_done);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // extreme words, a count dropped to one after re-arm, the last swap, an unknown type
  task automatic test_small_shuffle();
    set_entry_count(4);
    write_entry(0, 32'h8000_0000);
    write_entry(1, 32'h7FFF_FFFF);
    write_entry(2, 32'hFFFF_FFFF);
    write_entry(3, 32'h0000_0000);
    set_entry_count(1);
    step_to(0);
    set_entry_count(4);
    step_to(0);
    step_to(2);
    step_to(1);
    step_to(0);
    read_entry(0);
    read_entry(3);
    send_item(REQ_NONE, '1, '1, '1);
  endtask

  // zero count re-arms to cursor zero and the next step is done
  task automatic test_count_edges();
    set_entry_count(0);
    write_entry(5, 32'h1234_5678);
    step_to(0);
  endtask

  task automatic test_large_counts();
    set_entry_count(17'd65536);
    write_entry(65534, $urandom);
    write_entry(0, $urandom);
    write_entry(65535, $urandom);
    send_item(REQ_STEP, '0, '0, 31'h7FFF_FFFF);
    step_to(0);
    read_entry(65534);
    read_entry(0);
    set_entry_count(17'd65535);
    write_entry(65534, $urandom);
    step_to(0);
    read_entry(65535);
  endtask

  // receiver holds off while the sender keeps offering transfers
  task automatic test_backpressure();
    set_entry_count(10);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs++;
    for (int p = 0; p < 10; p++) write_entry(p, $urandom);
    for (int s = 0; s < 10; s++) step_random();
    for (int p = 0; p < 10; p++) read_entry(p);
  endtask

  task automatic run_shuffle_round(int unsigned n, int idle, int stall);
    int r;
    set_entry_count(CNT_W'(n));
    if ($urandom_range(3) == 0) begin
      send_idle_pct = 0;
      stall_pct     = 0;
    end else begin
      send_idle_pct = idle;
      stall_pct     = stall;
    end
    for (int unsigned p = 0; p < n; p++) write_entry(p, $urandom);
    for (int unsigned s = 0; s <= n; s++) begin
      r = $urandom_range(99);
      if (r < 10) read_random_entry();
      else if (r < 14) send_item(REQ_NONE, POS_W'($urandom), $urandom, RND_W'($urandom));
      else if (r < 17) write_entry($urandom_range(ENTRY_DEPTH - 1), $urandom);
      step_random();
    end
    repeat (3) read_random_entry();
  endtask

  task automatic run_random_phase(int idle, int stall, int item_total);
    int          target;
    int unsigned n;
    int          pick;
    target = items_sent + item_total;
    while (items_sent < target) begin
      pick = $urandom_range(15);
      if (pick == 0) n = $urandom_range(1);
      else if (pick == 1) n = $urandom_range(120, 60);
      else n = $urandom_range(24, 2);
      run_shuffle_round(n, idle, stall);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_small_shuffle();
    test_count_edges();
    test_large_counts();
    test_backpressure();
    run_random_phase(0, 0, 350);
    run_random_phase(79, 0, 350);
    run_random_phase(0, 79, 350);
    run_random_phase(8, 8, 350);
    quiesce();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: fisher_yates_shuffle.f
rtl/fys_pkg.sv
rtl/fys_ctrl.sv
rtl/fys_dp.sv
rtl/fisher_yates_shuffle.sv
bench/testbench.sv
